// ===== sv/lalb_pkg.sv =====
// Shared types and constants of the label adjacency list builder.
// No dependencies; imported by the interfaces, the list update, the core and the bench.
`timescale 1ns / 1ps
`default_nettype none

package lalb_pkg;

	// Width of one label and of the reported neighbour count
	localparam int LABEL_W   = 16;
	localparam int NB_CNT_W  = 3;
	// Neighbours offered per pixel (left, below, right, above) and slots reported
	localparam int NUM_CANDS = 4;
	localparam int OUT_SLOTS = 5;

	// Order in which the neighbours are offered to the list
	localparam int CAND_LEFT  = 0;
	localparam int CAND_BELOW = 1;
	localparam int CAND_RIGHT = 2;
	localparam int CAND_ABOVE = 3;

	typedef logic [LABEL_W-1:0]  label_t;
	typedef logic [NB_CNT_W-1:0] nb_cnt_t;
	typedef label_t [NUM_CANDS-1:0] cand_vec_t;

endpackage : lalb_pkg

`default_nettype wire

// ===== sv/lalb_if.sv =====
// Valid/ready channel interfaces: pixel beats in, adjacency list beats out.
// Depends on lalb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lalb_pixel_if;
	import lalb_pkg::*;

	logic   valid;
	logic   ready;
	label_t centre_label;
	label_t left_label;
	label_t below_label;
	label_t right_label;
	label_t above_label;

	modport source (
		output valid, centre_label, left_label, below_label, right_label, above_label,
		input  ready
	);
	modport sink (
		input  valid, centre_label, left_label, below_label, right_label, above_label,
		output ready
	);
endinterface : lalb_pixel_if

interface lalb_list_if;
	import lalb_pkg::*;

	logic    valid;
	logic    ready;
	logic    skipped;
	label_t  label_echo;
	nb_cnt_t neighbour_count;
	label_t  slot_a;
	label_t  slot_b;
	label_t  slot_c;
	label_t  slot_d;
	label_t  slot_e;

	modport source (
		output valid, skipped, label_echo, neighbour_count,
		output slot_a, slot_b, slot_c, slot_d, slot_e,
		input  ready
	);
	modport sink (
		input  valid, skipped, label_echo, neighbour_count,
		input  slot_a, slot_b, slot_c, slot_d, slot_e,
		output ready
	);
endinterface : lalb_list_if

`default_nettype wire

// ===== sv/lalb_entry_ram.sv =====
// Per-label list store: one write port, one read port, registered read data.
// Depends on nothing; the top level sets depth and word width.
`timescale 1ns / 1ps
`default_nettype none

module lalb_entry_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 83
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : lalb_entry_ram

`default_nettype wire

// ===== sv/lalb_list_update.sv =====
// Adds new nonzero non-self neighbour labels to a list while it has room.
// Depends on lalb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lalb_list_update #(
	parameter int MAX_NEIGHBOURS = 5,
	parameter int CNT_W          = 3
) (
	input  wire lalb_pkg::label_t                         centre,
	input  wire lalb_pkg::cand_vec_t                      cands,
	input  wire logic [CNT_W-1:0]                         cnt_in,
	input  wire logic [MAX_NEIGHBOURS-1:0][lalb_pkg::LABEL_W-1:0] slots_in,
	output logic      [CNT_W-1:0]                         cnt_out,
	output logic      [MAX_NEIGHBOURS-1:0][lalb_pkg::LABEL_W-1:0] slots_out
);
	import lalb_pkg::*;

	// Offer the candidates in order; each sees the list left by the one before
	always_comb begin
		logic [CNT_W-1:0] n;
		logic [MAX_NEIGHBOURS-1:0][LABEL_W-1:0] s;
		logic hit;
		n = cnt_in;
		s = slots_in;
		for (int c = 0; c < NUM_CANDS; c++) begin
			hit = 1'b0;
			for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
				if ((CNT_W'(k) < n) && (s[k] == cands[c])) begin
					hit = 1'b1;
				end
			end
			if ((n < CNT_W'(MAX_NEIGHBOURS)) && (cands[c] != '0) &&
			    (cands[c] != centre) && !hit) begin
				for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
					if (CNT_W'(k) == n) begin
						s[k] = cands[c];
					end
				end
				n = n + CNT_W'(1);
			end
		end
		cnt_out   = n;
		slots_out = s;
	end

endmodule : lalb_list_update

`default_nettype wire

// ===== sv/label_adjacency_list_builder_core.sv =====
// Result path: an accepted pixel beat is held in stage 1 while its list is read, then in the output register.
// Throughput: one pixel per cycle while result beats are taken; a read-modify-write of the list store per pixel,
// with the last written entry forwarded to a following pixel of the same label.
// Reset: a clearing pass writes every entry of the list store (LABEL_COUNT, 65536 by default),
// during which no pixel is accepted.
// Depends on lalb_pkg, lalb_if, lalb_entry_ram and lalb_list_update.
`timescale 1ns / 1ps
`default_nettype none

module label_adjacency_list_builder_core #(
	parameter int LABEL_COUNT    = 65536,
	parameter int MAX_NEIGHBOURS = 5
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lalb_pixel_if.sink  pixel,
	lalb_list_if.source adj_list
);
	import lalb_pkg::*;

	localparam int AW        = $clog2(LABEL_COUNT);
	localparam int CNT_W     = $clog2(MAX_NEIGHBOURS + 1);
	localparam int SLOT_BITS = MAX_NEIGHBOURS * LABEL_W;
	localparam int ENT_W     = CNT_W + SLOT_BITS;
	localparam int PAD_SLOTS = (MAX_NEIGHBOURS > OUT_SLOTS) ? MAX_NEIGHBOURS : OUT_SLOTS;

	// Clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// Stage 1: read in flight
	logic      v_s1;
	label_t    lab_s1;
	cand_vec_t cand_s1;

	// Forwarding of the last written entry
	logic             fwd_v_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [ENT_W-1:0] fwd_data_q;

	// Output register
	logic    out_v_q;
	logic    out_skip_q;
	label_t  out_lab_q;
	nb_cnt_t out_cnt_q;
	label_t [OUT_SLOTS-1:0] out_slot_q;

	logic accept, adv_s1, skip_s1;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic [ENT_W-1:0] rd_data, cur_ent;
	logic [CNT_W-1:0] cur_cnt, new_cnt;
	logic [MAX_NEIGHBOURS-1:0][LABEL_W-1:0] cur_slots, new_slots;
	logic [PAD_SLOTS-1:0][LABEL_W-1:0] wide_slots;
	logic [NB_CNT_W+CNT_W-1:0] cnt_ext;
	logic [3:0] cnt4;

	// Handshake
	assign accept       = pixel.valid && pixel.ready;
	assign adv_s1       = v_s1 && (!out_v_q || adj_list.ready);
	assign pixel.ready  = !clearing_q && (!v_s1 || adv_s1);
	assign skip_s1      = (lab_s1 == '0) || ({1'b0, lab_s1} >= (LABEL_W+1)'(LABEL_COUNT));

	// Clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(LABEL_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Stage 1 control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lab_s1              <= pixel.centre_label;
			cand_s1[CAND_LEFT]  <= pixel.left_label;
			cand_s1[CAND_BELOW] <= pixel.below_label;
			cand_s1[CAND_RIGHT] <= pixel.right_label;
			cand_s1[CAND_ABOVE] <= pixel.above_label;
		end
	end

	// List store
	lalb_entry_ram #(
		.DEPTH (LABEL_COUNT),
		.AW    (AW),
		.DW    (ENT_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (pixel.centre_label[AW-1:0]),
		.rdata (rd_data)
	);

	// Pick forwarded entry over stale read data
	assign cur_ent   = (fwd_v_q && (fwd_addr_q == lab_s1[AW-1:0])) ? fwd_data_q : rd_data;
	assign cur_cnt   = cur_ent[ENT_W-1 -: CNT_W];
	assign cur_slots = cur_ent[SLOT_BITS-1:0];

	lalb_list_update #(
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS),
		.CNT_W          (CNT_W)
	) u_update (
		.centre    (lab_s1),
		.cands     (cand_s1),
		.cnt_in    (cur_cnt),
		.slots_in  (cur_slots),
		.cnt_out   (new_cnt),
		.slots_out (new_slots)
	);

	// Write port: clearing sweep or write-back
	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = adv_s1 && !skip_s1;
			mem_waddr = lab_s1[AW-1:0];
			mem_wdata = {new_cnt, new_slots};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (clearing_q) begin
			fwd_v_q <= 1'b0;
		end else if (adv_s1 && !skip_s1) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clearing_q && adv_s1 && !skip_s1) begin
			fwd_addr_q <= lab_s1[AW-1:0];
			fwd_data_q <= {new_cnt, new_slots};
		end
	end

	// Result formatting: count masked to the port width, slots above count zeroed
	assign wide_slots = (PAD_SLOTS*LABEL_W)'(new_slots);
	assign cnt_ext    = {NB_CNT_W'(0), new_cnt};
	assign cnt4       = 4'(new_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1) begin
			out_v_q <= 1'b1;
		end else if (adj_list.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_skip_q <= skip_s1;
			out_lab_q  <= lab_s1;
			out_cnt_q  <= skip_s1 ? '0 : cnt_ext[NB_CNT_W-1:0];
			for (int j = 0; j < OUT_SLOTS; j++) begin
				out_slot_q[j] <= (!skip_s1 && (cnt4 > 4'(j))) ? wide_slots[j] : '0;
			end
		end
	end

	assign adj_list.valid           = out_v_q;
	assign adj_list.skipped         = out_skip_q;
	assign adj_list.label_echo      = out_lab_q;
	assign adj_list.neighbour_count = out_cnt_q;
	assign adj_list.slot_a          = out_slot_q[0];
	assign adj_list.slot_b          = out_slot_q[1];
	assign adj_list.slot_c          = out_slot_q[2];
	assign adj_list.slot_d          = out_slot_q[3];
	assign adj_list.slot_e          = out_slot_q[4];

	// Checks
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clearing pass restarted");

	a_write_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !clearing_q) |-> (adv_s1 && !skip_s1))
		else $error("list store written without a retiring pixel");

	a_cnt_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !skip_s1 && !clearing_q) |-> (new_cnt >= cur_cnt))
		else $error("list count shrank");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !skip_s1 && !clearing_q) |-> (new_cnt <= CNT_W'(MAX_NEIGHBOURS)))
		else $error("list count above capacity");

	a_skip_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_skip_q) |-> (out_cnt_q == '0))
		else $error("skipped beat with nonzero count");

endmodule : label_adjacency_list_builder_core

`default_nettype wire

// ===== dv/tb_label_adjacency_list_builder_core.sv =====
// Self-checking bench for label_adjacency_list_builder_core: pixel beats in, adjacency lists out.
// Keeps its own per-label neighbour lists and compares every list beat against them.
// Depends on lalb_pkg, lalb_if and the core RTL.
`timescale 1ns / 1ps

module tb_label_adjacency_list_builder_core;
	import lalb_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int LABEL_COUNT    = 65536;
	localparam int MAX_NEIGHBOURS = 5;
	localparam int HOT_N          = 24;
	localparam int RAND_PER_PHASE = 530;
	localparam int IDLE_LIGHT     = 22;
	localparam int IDLE_HEAVY     = 64;
	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int TAIL_CYCLES    = 8;
	// clearing pass plus a slow run, several times over
	localparam int TIMEOUT_CYCLES = 600000;

	typedef struct packed {
		label_t centre;
		label_t left;
		label_t below;
		label_t right;
		label_t above;
	} pixel_beat_t;

	typedef struct {
		pixel_beat_t px;
		int          send_idle;
		int          recv_idle;
		bit          drain_first;
	} pending_pixel_t;

	// slots[0] is slot_a
	typedef struct packed {
		logic                    skipped;
		label_t                  label_echo;
		nb_cnt_t                 neighbour_count;
		label_t [OUT_SLOTS-1:0]  slots;
	} list_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	lalb_pixel_if pixel_bus ();
	lalb_list_if  list_bus ();

	label_adjacency_list_builder_core #(
		.LABEL_COUNT    (LABEL_COUNT),
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pixel_bus),
		.adj_list (list_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the per-label neighbour lists
	bit [3:0]         adj_len   [LABEL_COUNT];
	bit [LABEL_W-1:0] adj_slots [LABEL_COUNT][MAX_NEIGHBOURS];

	pending_pixel_t pixel_queue [$];
	list_beat_t     expected_lists [$];
	label_t         hot_pool [HOT_N];
	int             recv_stall_pct = IDLE_HEAVY;
	int             fail_count = 0;

	// Offer the four neighbours in the order left, below, right, above and report the centre's list, or a skipped beat
	function automatic list_beat_t predict_list(pixel_beat_t px);
		list_beat_t r;
		label_t     cands [NUM_CANDS];
		int         n;
		bit         listed;
		r            = '0;
		r.label_echo = px.centre;
		if (px.centre == '0 || int'(px.centre) >= LABEL_COUNT) begin
			r.skipped = 1'b1;
			return r;
		end
		cands[CAND_LEFT]  = px.left;
		cands[CAND_BELOW] = px.below;
		cands[CAND_RIGHT] = px.right;
		cands[CAND_ABOVE] = px.above;
		for (int i = 0; i < NUM_CANDS; i++) begin
			n      = adj_len[px.centre];
			listed = 1'b0;
			for (int k = 0; k < n; k++)
				if (adj_slots[px.centre][k] == cands[i])
					listed = 1'b1;
			if (n < MAX_NEIGHBOURS && cands[i] != '0 && cands[i] != px.centre && !listed) begin
				adj_slots[px.centre][n] = cands[i];
				adj_len[px.centre]      = n + 1;
			end
		end
		n                 = adj_len[px.centre];
		r.neighbour_count = nb_cnt_t'(n);
		for (int k = 0; k < n && k < OUT_SLOTS; k++)
			r.slots[k] = adj_slots[px.centre][k];
		return r;
	endfunction

	function automatic string list_str(list_beat_t b);
		return $sformatf("skip=%0b label=%h count=%0d slots=%h %h %h %h %h",
			b.skipped, b.label_echo, b.neighbour_count,
			b.slots[0], b.slots[1], b.slots[2], b.slots[3], b.slots[4]);
	endfunction

	task automatic queue_pixel(input label_t c, l, b, r, a,
			input int send_idle, recv_idle, input bit drain_first);
		pending_pixel_t p;
		p.px          = '{centre: c, left: l, below: b, right: r, above: a};
		p.send_idle   = send_idle;
		p.recv_idle   = recv_idle;
		p.drain_first = drain_first;
		pixel_queue.insert(pixel_queue.size(), p);
	endtask

	// Mostly labels already in play, so lists fill up, repeat and collide
	function automatic label_t pick_neighbour(label_t centre);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return '0;
		else if (roll < 35)
			return centre;
		else if (roll < 75)
			return hot_pool[$urandom_range(HOT_N - 1)];
		return label_t'($urandom);
	endfunction

	// Pixel driver: predict on acceptance, then offer the next beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bus.valid        <= 1'b0;
			pixel_bus.centre_label <= '0;
			pixel_bus.left_label   <= '0;
			pixel_bus.below_label  <= '0;
			pixel_bus.right_label  <= '0;
			pixel_bus.above_label  <= '0;
		end else begin
			if (pixel_bus.valid && pixel_bus.ready)
				expected_lists.insert(expected_lists.size(), predict_list('{
					centre: pixel_bus.centre_label, left: pixel_bus.left_label,
					below: pixel_bus.below_label, right: pixel_bus.right_label,
					above: pixel_bus.above_label}));
			if (!pixel_bus.valid || pixel_bus.ready) begin
				if (pixel_queue.size() == 0)
					pixel_bus.valid <= 1'b0;
				else if (pixel_queue[0].drain_first && expected_lists.size() != 0)
					pixel_bus.valid <= 1'b0;
				else if ($urandom_range(99) < pixel_queue[0].send_idle)
					pixel_bus.valid <= 1'b0;
				else begin
					pixel_bus.valid        <= 1'b1;
					pixel_bus.centre_label <= pixel_queue[0].px.centre;
					pixel_bus.left_label   <= pixel_queue[0].px.left;
					pixel_bus.below_label  <= pixel_queue[0].px.below;
					pixel_bus.right_label  <= pixel_queue[0].px.right;
					pixel_bus.above_label  <= pixel_queue[0].px.above;
					recv_stall_pct         <= pixel_queue[0].recv_idle;
					void'(pixel_queue.pop_front());
				end
			end
		end
	end

	// List monitor: random backpressure, compare each beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_bus.ready <= 1'b0;
		end else begin
			if (list_bus.valid && list_bus.ready) begin : check_beat
				list_beat_t got;
				list_beat_t want;
				got.skipped         = list_bus.skipped;
				got.label_echo      = list_bus.label_echo;
				got.neighbour_count = list_bus.neighbour_count;
				got.slots           = {list_bus.slot_e, list_bus.slot_d, list_bus.slot_c,
					list_bus.slot_b, list_bus.slot_a};
				if (expected_lists.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t: list beat with no pixel pending: %s", $realtime,
							list_str(got));
					fail_count++;
				end else begin
					want = expected_lists.pop_front();
					if (got.skipped !== want.skipped || got.label_echo !== want.label_echo
							|| got.neighbour_count !== want.neighbour_count
							|| got.slots !== want.slots) begin
						if (fail_count < MAX_REPORTS)
							$display("%0t: list mismatch\n  exp %s\n  got %s", $realtime,
								list_str(want), list_str(got));
						fail_count++;
					end
				end
			end
			list_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus, reset and end of run
	initial begin : main_seq
		label_t centre;
		label_t prev_centre;
		int     roll;
		int     send_pct;
		int     recv_pct;
		int     waited;

		arst_n                 = 1'b0;
		pixel_bus.valid        = 1'b0;
		pixel_bus.centre_label = '0;
		pixel_bus.left_label   = '0;
		pixel_bus.below_label  = '0;
		pixel_bus.right_label  = '0;
		pixel_bus.above_label  = '0;
		list_bus.ready         = 1'b0;

		// Directed: no-tile pixels, extremes, self and zero neighbours,
		// duplicates, overflow of a full list, back-to-back same label
		queue_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, IDLE_LIGHT, IDLE_HEAVY, 0);
		queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, IDLE_LIGHT, IDLE_HEAVY, 0);
		queue_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0001, IDLE_LIGHT, IDLE_HEAVY, 0);
		queue_pixel(16'hFFFF, 16'h0002, 16'h0003, 16'h0004, 16'h0005, IDLE_LIGHT, IDLE_HEAVY, 0);
		queue_pixel(16'hFFFF, 16'h0006, 16'h0007, 16'h0008, 16'h0009, IDLE_LIGHT, IDLE_HEAVY, 0);
		queue_pixel(16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000, IDLE_LIGHT, IDLE_HEAVY, 0);
		queue_pixel(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, IDLE_LIGHT, IDLE_HEAVY, 0);
		queue_pixel(16'h8000, 16'h0001, 16'hAAAA, 16'h5555, 16'h1234, IDLE_LIGHT, IDLE_HEAVY, 0);
		queue_pixel(16'h0100, 16'h0A00, 16'h0B00, 16'h0C00, 16'h0D00, 0, 0, 1);
		queue_pixel(16'h0100, 16'h0E00, 16'h0F00, 16'h1000, 16'h1100, 0, 0, 0);
		queue_pixel(16'h0002, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
		queue_pixel(16'h0002, 16'h0003, 16'h0004, 16'h0002, 16'h0003, 0, 0, 0);
		queue_pixel(16'h0002, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 0, 0, 0);
		queue_pixel(16'h0002, 16'h0008, 16'h0003, 16'h0009, 16'h0000, 0, 0, 0);
		queue_pixel(16'h0000, 16'h0002, 16'h0002, 16'h0002, 16'h0002, 0, 0, 0);
		queue_pixel(16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, IDLE_LIGHT, IDLE_HEAVY, 0);
		queue_pixel(16'hAAAA, 16'h5555, 16'h0000, 16'hAAAA, 16'hFFFF, IDLE_LIGHT, IDLE_HEAVY, 0);

		// Random: a pool of hot labels, slowly refreshed so new lists keep starting
		for (int i = 0; i < HOT_N; i++)
			hot_pool[i] = label_t'($urandom);
		prev_centre = hot_pool[0];
		for (int ph = 0; ph < 3; ph++) begin
			send_pct = (ph == 0) ? IDLE_LIGHT : (ph == 1) ? IDLE_HEAVY : 0;
			recv_pct = (ph == 0) ? IDLE_HEAVY : (ph == 1) ? IDLE_LIGHT : 0;
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				roll = $urandom_range(99);
				if (roll < 6)
					centre = '0;
				else if (roll < 20)
					centre = prev_centre;
				else if (roll < 75)
					centre = hot_pool[$urandom_range(HOT_N - 1)];
				else
					centre = label_t'($urandom);
				if ($urandom_range(7) == 0)
					hot_pool[$urandom_range(HOT_N - 1)] = label_t'($urandom);
				queue_pixel(centre, pick_neighbour(centre), pick_neighbour(centre),
					pick_neighbour(centre), pick_neighbour(centre), send_pct, recv_pct,
					(i == 0) || ($urandom_range(199) == 0));
				prev_centre = centre;
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// The clearing pass holds off pixels; the watchdog bounds it
		while (pixel_queue.size() != 0 || pixel_bus.valid)
			@(posedge clk);
		waited = 0;
		while (expected_lists.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_lists.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("FAILED: results differ");
		$finish;
	end

endmodule : tb_label_adjacency_list_builder_core
